// ===== src/pcn_pkg.sv =====
// ---------------------------------------------------------------------------
// pcn_pkg: shared definitions for the pin change notification port
// Codes for item kinds and register selects, field widths and defaults.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pcn_pkg;

   // Field widths
   localparam int unsigned KindWidth  = 2;
   localparam int unsigned SelWidth   = 3;
   localparam int unsigned DataWidth  = 16;
   localparam int unsigned PinWidth   = 16;
   localparam int unsigned ReqDataW   = 32;   // write_data, pin_levels
   localparam int unsigned ReqUserW   = 5;    // kind, reg_select
   localparam int unsigned RspDataW   = 40;   // read_data, irq, new_edges, pad

   // Default number of pins that exist on the port
   localparam int unsigned PinCountDefault = 16;

   // Item kinds
   typedef enum logic [KindWidth-1:0] {
      KIND_TICK  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_READ  = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   // Register selects
   localparam logic [SelWidth-1:0] SelControl = 3'd0;
   localparam logic [SelWidth-1:0] SelRiseEn  = 3'd1;
   localparam logic [SelWidth-1:0] SelFallEn  = 3'd2;
   localparam logic [SelWidth-1:0] SelFlags   = 3'd3;
   localparam logic [SelWidth-1:0] SelSummary = 3'd4;
   localparam logic [SelWidth-1:0] SelIrqEn   = 3'd5;

   // Control register bit positions
   localparam int unsigned CtrlOnBit    = 15;
   localparam int unsigned CtrlStyleBit = 11;

   // Configuration register indexes
   localparam logic CfgInputMask = 1'b0;

endpackage : pcn_pkg

`default_nettype wire

// ===== src/pin_change_notification_port_top.sv =====
// A request passes through the input register, then the result register, before
// its result is presented.
// Throughput: one item per cycle; the input stalls only while a result waits
// and the input register is already full.
// The sticky flag and edge update is a single pass of masking logic per item.
// Reset (synchronous, active high) clears the valid bits and block state; the
// data registers are not reset, and input_mask returns to all ones.
// ---------------------------------------------------------------------------
// pin_change_notification_port_top: edge-style change notification port
// Samples pin levels on ticks, latches qualified edges into sticky flags,
// and serves register reads and writes arriving on the same stream.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pin_change_notification_port_top #(
   parameter int unsigned PIN_COUNT = pcn_pkg::PinCountDefault
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request stream
   input  wire logic                          req_tvalid,
   output      logic                          req_tready,
   input  wire logic [pcn_pkg::ReqDataW-1:0]  req_tdata,  // [15:0] write_data, [31:16] pin_levels
   input  wire logic [pcn_pkg::ReqUserW-1:0]  req_tuser,  // [1:0] kind, [4:2] reg_select
   // result stream
   output      logic                          rsp_tvalid,
   input  wire logic                          rsp_tready,
   output      logic [pcn_pkg::RspDataW-1:0]  rsp_tdata,  // [15:0] read_data,
                                                           // [16] interrupt_request,
                                                           // [32:17] new_edges, [39:33] zero
   // configuration port
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [2:0]                    csr_paddr,
   input  wire logic [31:0]                   csr_pwdata,
   output      logic [31:0]                   csr_prdata,
   output      logic                          csr_pready
);
   import pcn_pkg::*;

   // Pins that exist on this port
   localparam int unsigned PresentCount = (PIN_COUNT >= PinWidth) ? PinWidth : PIN_COUNT;
   localparam logic [31:0] PresentWide  = (32'd1 << PresentCount) - 32'd1;
   localparam logic [PinWidth-1:0] PresentMask = PresentWide[PinWidth-1:0];

   // Configuration
   logic [PinWidth-1:0] input_mask_ff;
   logic                cfg_write;

   // Block state
   logic                ctrl_on_ff, ctrl_on_in;
   logic                ctrl_edge_ff, ctrl_edge_in;
   logic [PinWidth-1:0] rise_en_ff, rise_en_in;
   logic [PinWidth-1:0] fall_en_ff, fall_en_in;
   logic [PinWidth-1:0] flags_ff, flags_in;
   logic [PinWidth-1:0] prev_ff, prev_in;
   logic                summary_ff, summary_in;
   logic                irq_en_ff, irq_en_in;

   // Input register
   logic                 in_valid_ff;
   kind_type             kind_ff;
   logic [SelWidth-1:0]  sel_ff;
   logic [DataWidth-1:0] wdata_ff;
   logic [PinWidth-1:0]  levels_ff;

   // Result register
   logic                 out_valid_ff;
   logic [RspDataW-1:0]  out_data_ff;

   // Per-item results
   logic [DataWidth-1:0] rdata;
   logic [PinWidth-1:0]  edges;
   logic [PinWidth-1:0]  rise;
   logic [PinWidth-1:0]  fall;
   logic                 advance;

   // Handshake: the input register moves on when the result register is free
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // Configuration port: zero-wait, one register
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == CfgInputMask) ? {16'd0, input_mask_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         input_mask_ff <= '1;
      end else if (cfg_write && csr_paddr[2] == CfgInputMask) begin
         input_mask_ff <= csr_pwdata[PinWidth-1:0];
      end
   end

   // Edge detection, flag update and register access for the held item
   assign rise = levels_ff & ~prev_ff;
   assign fall = prev_ff & ~levels_ff;

   always_comb begin
      ctrl_on_in   = ctrl_on_ff;
      ctrl_edge_in = ctrl_edge_ff;
      rise_en_in   = rise_en_ff;
      fall_en_in   = fall_en_ff;
      flags_in     = flags_ff;
      prev_in      = prev_ff;
      summary_in   = summary_ff;
      irq_en_in    = irq_en_ff;
      rdata        = '0;
      edges        = '0;
      unique case (kind_ff)
         KIND_TICK: begin
            if (ctrl_on_ff && ctrl_edge_ff) begin
               edges = ((rise & rise_en_ff) | (fall & fall_en_ff)) & input_mask_ff
                       & PresentMask;
            end
            if (edges != '0) begin
               flags_in   = flags_ff | edges;
               summary_in = 1'b1;
            end
            prev_in = levels_ff;
         end
         KIND_WRITE: begin
            unique case (sel_ff)
               SelControl: begin
                  ctrl_on_in   = wdata_ff[CtrlOnBit];
                  ctrl_edge_in = wdata_ff[CtrlStyleBit];
               end
               SelRiseEn:  rise_en_in = wdata_ff & PresentMask;
               SelFallEn:  fall_en_in = wdata_ff & PresentMask;
               SelFlags:   flags_in   = wdata_ff & PresentMask;
               SelSummary: summary_in = wdata_ff[0];
               SelIrqEn:   irq_en_in  = wdata_ff[0];
               default: ;
            endcase
         end
         KIND_READ: begin
            unique case (sel_ff)
               SelControl: begin
                  rdata[CtrlOnBit]    = ctrl_on_ff;
                  rdata[CtrlStyleBit] = ctrl_edge_ff;
               end
               SelRiseEn:  rdata = rise_en_ff;
               SelFallEn:  rdata = fall_en_ff;
               SelFlags:   rdata = flags_ff;
               SelSummary: rdata = {15'd0, summary_ff};
               SelIrqEn:   rdata = {15'd0, irq_en_ff};
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   // Commit state when the held item moves into the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_on_ff   <= 1'b0;
         ctrl_edge_ff <= 1'b0;
         rise_en_ff   <= '0;
         fall_en_ff   <= '0;
         flags_ff     <= '0;
         prev_ff      <= '0;
         summary_ff   <= 1'b0;
         irq_en_ff    <= 1'b0;
      end else if (advance) begin
         ctrl_on_ff   <= ctrl_on_in;
         ctrl_edge_ff <= ctrl_edge_in;
         rise_en_ff   <= rise_en_in;
         fall_en_ff   <= fall_en_in;
         flags_ff     <= flags_in;
         prev_ff      <= prev_in;
         summary_ff   <= summary_in;
         irq_en_ff    <= irq_en_in;
      end
   end

   // Input register: capture each request transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         kind_ff   <= kind_type'(req_tuser[KindWidth-1:0]);
         sel_ff    <= req_tuser[KindWidth +: SelWidth];
         wdata_ff  <= req_tdata[DataWidth-1:0];
         levels_ff <= req_tdata[DataWidth +: PinWidth];
      end
   end

   // Result register: hold until the result transfer completes
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= {7'd0, edges, summary_in & irq_en_in, rdata};
      end
   end

endmodule : pin_change_notification_port_top

`default_nettype wire

// ===== src/pcn_checker.sv =====
// ---------------------------------------------------------------------------
// pcn_checker: port-level checks for the pin change notification port
// Watches the result stream and configuration port over time.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcn_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          rsp_tvalid,
   input wire logic                          rsp_tready,
   input wire logic [pcn_pkg::RspDataW-1:0]  rsp_tdata,
   input wire logic                          csr_pready
);
   import pcn_pkg::*;

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // Drop results out of reset
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // A tick never carries read data
   a_edges_no_read: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[32:17] != 16'd0 |-> rsp_tdata[15:0] == 16'd0)
      else $error("edges and read data in one result");

   // Keep the padding bits clear
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RspDataW-1:33] == '0)
      else $error("padding bits set in result");

   // Configuration accesses never wait
   a_pready: assert property (@(posedge clock) disable iff (reset)
      csr_pready)
      else $error("configuration port stalled");

endmodule : pcn_checker

bind pin_change_notification_port_top pcn_checker u_pcn_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_pready (csr_pready)
);

`default_nettype wire

// ===== verif/pcn_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pcn_scoreboard: result checker for the pin change notification port
// Watches the request, result and configuration channels, keeps its own copy
// of the port state, predicts one result per request transfer and compares
// each result transfer against the oldest prediction, field by field.
// ---------------------------------------------------------------------------

module pcn_scoreboard #(
   parameter int unsigned PIN_COUNT = pcn_pkg::PinCountDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,    // [15:0] write_data, [31:16] pin_levels
   input  logic [4:0]  req_tuser,    // [1:0] kind, [4:2] reg_select
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,    // [15:0] read_data, [16] interrupt_request,
                                     // [32:17] new_edges, [39:33] zero
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          failures,
   output int          pending
);
   import pcn_pkg::*;

   localparam logic [15:0] PinsPresent =
      (PIN_COUNT >= 16) ? 16'hFFFF : 16'((32'd1 << PIN_COUNT) - 32'd1);
   localparam logic [2:0] MaskAddr = 3'(4 * CfgInputMask);

   typedef struct packed {
      logic [15:0] read_data;
      logic        irq;
      logic [15:0] new_edges;
   } port_report_type;

   // Results still owed by the port, oldest first
   port_report_type expected_reports[$];

   // Mirror of the port state
   logic [15:0] input_mask;
   logic        module_on;
   logic        edge_style;
   logic [15:0] rise_en;
   logic [15:0] fall_en;
   logic [15:0] change_flags;
   logic [15:0] prev_levels;
   logic        summary;
   logic        irq_en;

   initial failures = 0;
   initial pending = 0;

   // Apply one request to the mirrored state and return the result it causes
   function automatic port_report_type predict_report(kind_type kind, logic [2:0] sel,
                                                      logic [15:0] wdata,
                                                      logic [15:0] levels);
      port_report_type rep;
      logic [15:0]     rising;
      logic [15:0]     falling;
      rep = '0;
      case (kind)
         KIND_TICK: begin
            // only edge style with the module on latches anything
            if (module_on && edge_style) begin
               rising = levels & ~prev_levels;
               falling = prev_levels & ~levels;
               rep.new_edges = ((rising & rise_en) | (falling & fall_en))
                               & input_mask & PinsPresent;
               if (rep.new_edges != '0) begin
                  change_flags = change_flags | rep.new_edges;
                  summary = 1'b1;
               end
            end
            prev_levels = levels;
         end
         KIND_WRITE: begin
            case (sel)
               SelControl: begin
                  module_on = wdata[CtrlOnBit];
                  edge_style = wdata[CtrlStyleBit];
               end
               SelRiseEn:  rise_en = wdata & PinsPresent;
               SelFallEn:  fall_en = wdata & PinsPresent;
               SelFlags:   change_flags = wdata & PinsPresent;
               SelSummary: summary = wdata[0];
               SelIrqEn:   irq_en = wdata[0];
               default: ;
            endcase
         end
         KIND_READ: begin
            case (sel)
               SelControl: begin
                  rep.read_data[CtrlOnBit] = module_on;
                  rep.read_data[CtrlStyleBit] = edge_style;
               end
               SelRiseEn:  rep.read_data = rise_en;
               SelFallEn:  rep.read_data = fall_en;
               SelFlags:   rep.read_data = change_flags;
               SelSummary: rep.read_data[0] = summary;
               SelIrqEn:   rep.read_data[0] = irq_en;
               default: ;
            endcase
         end
         default: ;
      endcase
      rep.irq = summary & irq_en;
      return rep;
   endfunction

   task automatic compare_field(string field, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %h, got %h", field, want, got);
         failures++;
      end
   endtask

   // Sample all channels on the rising edge
   always @(posedge clock) begin : monitor
      port_report_type got;
      port_report_type want;
      if (reset) begin
         input_mask = 16'hFFFF;
         module_on = 1'b0;
         edge_style = 1'b0;
         rise_en = '0;
         fall_en = '0;
         change_flags = '0;
         prev_levels = '0;
         summary = 1'b0;
         irq_en = 1'b0;
         expected_reports.delete();
      end else begin
         // results come from earlier requests, so check before predicting
         if (rsp_tvalid && rsp_tready) begin
            got.read_data = rsp_tdata[15:0];
            got.irq = rsp_tdata[16];
            got.new_edges = rsp_tdata[32:17];
            if (expected_reports.size() == 0) begin
               $error("result transfer with no request outstanding: tdata %h", rsp_tdata);
               failures++;
            end else begin
               want = expected_reports.pop_front();
               compare_field("read_data", want.read_data, got.read_data);
               compare_field("interrupt_request", 16'(want.irq), 16'(got.irq));
               compare_field("new_edges", want.new_edges, got.new_edges);
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == MaskAddr)
            input_mask = csr_pwdata[15:0];
         if (req_tvalid && req_tready)
            expected_reports.push_back(predict_report(kind_type'(req_tuser[1:0]),
                                                      req_tuser[4:2], req_tdata[15:0],
                                                      req_tdata[31:16]));
      end
      pending = expected_reports.size();
   end

endmodule

// ===== verif/pin_change_notification_port_top_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pin_change_notification_port_top_tb: stimulus and verdict for the port
// Runs a directed pass over registers, edge cases and control modes, then
// random phases under several input masks with random idling on both
// streams, a long result hold-off and a burst phase with no idling.
// ---------------------------------------------------------------------------

module pin_change_notification_port_top_tb;
   import pcn_pkg::*;

   localparam int unsigned   HoldCycles   = 400;
   localparam int unsigned   PhaseItems   = 180;
   localparam int unsigned   PhaseCount   = 5;
   localparam logic [2:0]    SelSpareLo   = 3'd6;
   localparam logic [2:0]    SelSpareHi   = 3'd7;
   localparam logic [2:0]    MaskAddr     = 3'(4 * CfgInputMask);
   localparam logic [15:0]   CtrlOnBitV   = 16'(1 << CtrlOnBit);
   localparam logic [15:0]   CtrlStyleV   = 16'(1 << CtrlStyleBit);
   localparam logic [15:0]   CtrlOnEdge   = CtrlOnBitV | CtrlStyleV;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;     // [15:0] write_data, [31:16] pin_levels
   logic [4:0]  req_tuser;     // [1:0] kind, [4:2] reg_select
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;     // [15:0] read_data, [16] interrupt_request,
                               // [32:17] new_edges, [39:33] zero
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          failures;
   int          pending;

   bit          no_idle;
   bit          hold_off_request;
   logic [15:0] last_levels;

   pin_change_notification_port_top uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   pcn_scoreboard #(.PIN_COUNT(PinCountDefault)) u_scoreboard (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_pready(csr_pready),
      .failures(failures), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Give up well past the slowest legal run
   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // Mostly short gaps, a few long ones
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Result side: random stalls, one long hold-off on request
   initial begin : receiver
      int stall;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off_request) begin
            rsp_tready = 1'b0;
            repeat (HoldCycles) @(negedge clock);
            hold_off_request = 1'b0;
         end else if (no_idle) begin
            rsp_tready = 1'b1;
            @(negedge clock);
         end else begin
            stall = idle_length();
            if (stall > 0) begin
               rsp_tready = 1'b0;
               repeat (stall) @(negedge clock);
            end
            rsp_tready = 1'b1;
            @(negedge clock);
         end
      end
   end

   // Offer one request and hold it until the transfer; starts and ends at a falling edge
   task automatic send_item(kind_type kind, logic [2:0] sel, logic [15:0] wdata,
                            logic [15:0] levels);
      int gap;
      gap = no_idle ? 0 : idle_length();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = {levels, wdata};
      req_tuser = {sel, kind};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      if (kind == KIND_TICK) last_levels = levels;
   endtask

   task automatic tick(logic [15:0] levels);
      send_item(KIND_TICK, 3'($urandom_range(0, 7)), 16'($urandom), levels);
   endtask

   task automatic write_reg(logic [2:0] sel, logic [15:0] data);
      send_item(KIND_WRITE, sel, data, 16'($urandom));
   endtask

   task automatic read_reg(logic [2:0] sel);
      send_item(KIND_READ, sel, 16'($urandom), 16'($urandom));
   endtask

   // Bus write of the input mask: setup phase, then access phase
   task automatic write_input_mask(logic [15:0] value);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = MaskAddr;
      csr_pwdata = {16'h0000, value};
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   // Stop offering and wait until every result has come back
   task automatic drain();
      req_tvalid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Weighted random item: mostly ticks near the last levels, with register traffic
   task automatic random_item();
      int          r;
      logic [15:0] data;
      r = $urandom_range(0, 99);
      data = 16'($urandom);
      if (r < 55) begin
         if ($urandom_range(0, 2) != 0)
            tick(last_levels ^ 16'(1 << $urandom_range(0, 15))
                 ^ (($urandom_range(0, 1) != 0) ? 16'(1 << $urandom_range(0, 15)) : 16'h0));
         else
            tick(16'($urandom));
      end else if (r < 75) begin
         case ($urandom_range(0, 9))
            0, 1: write_reg(SelControl, ($urandom_range(0, 4) != 0) ? (data | CtrlOnEdge) : data);
            2: write_reg(SelRiseEn, data);
            3: write_reg(SelFallEn, data);
            4: write_reg(SelFlags, data);
            5: write_reg(SelSummary, data);
            6: write_reg(SelIrqEn, data);
            7: write_reg(SelFlags, 16'h0000);
            8: write_reg(SelSummary, 16'h0000);
            default: write_reg(($urandom_range(0, 1) != 0) ? SelSpareHi : SelSpareLo, data);
         endcase
      end else if (r < 95) begin
         read_reg(3'($urandom_range(0, 7)));
      end else begin
         send_item(KIND_NONE, 3'($urandom_range(0, 7)), data, 16'($urandom));
      end
   endtask

   initial begin : stimulus
      logic [15:0] mask;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      no_idle = 1'b0;
      hold_off_request = 1'b0;
      last_levels = '0;
      repeat (2) @(negedge clock);
      reset = 1'b0;

      // Directed pass
      write_input_mask(16'hFFFF);
      read_reg(SelControl);
      tick(16'hFFFF);                      // module off: nothing latches
      write_reg(SelControl, CtrlOnEdge);
      read_reg(SelControl);
      write_reg(SelRiseEn, 16'hFFFF);
      write_reg(SelFallEn, 16'h0000);
      tick(16'h0000);                      // falls not enabled
      tick(16'hFFFF);                      // every pin rises
      write_reg(SelIrqEn, 16'h0001);
      read_reg(SelFlags);
      write_reg(SelFallEn, 16'hFFFF);      // both enables: any change
      tick(16'h0000);                      // edges on pins already flagged
      write_reg(SelFlags, 16'h0000);
      write_reg(SelSummary, 16'h0000);
      read_reg(SelSummary);
      read_reg(SelIrqEn);
      write_reg(SelSpareLo, 16'hFFFF);
      read_reg(SelSpareHi);
      send_item(KIND_NONE, SelFlags, 16'hFFFF, 16'hFFFF);
      write_reg(SelControl, CtrlStyleV);   // edge style, module off
      tick(16'h1234);
      write_reg(SelControl, CtrlOnBitV);   // module on, mismatch style
      tick(16'hEDCB);
      write_reg(SelControl, 16'hFFFF);
      tick(16'h5A5A);
      read_reg(SelRiseEn);
      drain();

      // Random phases under different masks
      for (int phase = 0; phase < PhaseCount; phase++) begin
         case (phase)
            0: mask = 16'h0000;
            2: mask = 16'hFFFF;
            default: mask = 16'($urandom);
         endcase
         write_input_mask(mask);
         no_idle = (phase == 3);
         if (phase == 1) hold_off_request = 1'b1;
         write_reg(SelControl, CtrlOnEdge);
         write_reg(SelRiseEn, 16'($urandom));
         write_reg(SelFallEn, 16'($urandom));
         write_reg(SelIrqEn, 16'h0001);
         repeat (PhaseItems) random_item();
         drain();
      end
      no_idle = 1'b0;

      repeat (10) @(negedge clock);
      if (failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== files.f =====
src/pcn_pkg.sv
src/pin_change_notification_port_top.sv
src/pcn_checker.sv
verif/pcn_checker.sv
verif/pin_change_notification_port_top_tb.sv
